### design/linear_value_smoother_assert.svh
// assertion macros for the linear value smoother
`ifndef LINEAR_VALUE_SMOOTHER_ASSERT_SVH
`define LINEAR_VALUE_SMOOTHER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LVS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// expression holds at every clock edge
`define LVS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`else

`define LVS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define LVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define LVS_ASSERT_ALWAYS(label, clk, rst, expr, msg)

`endif

`endif

### design/lvs_pkg.sv
`default_nettype none

package lvs_pkg;

   localparam int LEVEL_W = 48;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 16;
   localparam int DIST_W = LEVEL_W + 1;
   localparam int QUO_W = DIST_W + 1;
   localparam int DIV_STEPS = QUO_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [1:0] OP_SET_TARGET = 2'd0;
   localparam logic [1:0] OP_JUMP = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] sample_count;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] current_value;
      logic ramping;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_DIV_FIX,
      ST_MUL_HI,
      ST_ACCUM,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic div_load;
      logic div_step;
      logic div_finish;
      logic jump;
      logic snap;
      logic mul_lo;
      logic mul_hi;
      logic accum;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic target_differs;
      logic count_zero;
      logic left_zero;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

### design/lvs_dpath.sv
`default_nettype none

module lvs_dpath (
   input wire logic clock,
   input wire logic reset,
   input wire lvs_pkg::cmd_type cmd,
   output lvs_pkg::status_type status,
   input wire lvs_pkg::req_type req_payload,
   input wire logic csr_write_enable,
   input wire logic [lvs_pkg::COUNT_W-1:0] csr_write_data,
   output logic rsp_valid,
   output lvs_pkg::rsp_type rsp_payload,
   input wire logic rsp_stall
);
   import lvs_pkg::*;

   req_type req_ff, req_in;
   logic [COUNT_W-1:0] ramp_length_ff, ramp_length_in;
   logic signed [LEVEL_W-1:0] current_ff, current_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic signed [LEVEL_W-1:0] step_ff, step_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [COUNT_W-1:0] divisor_ff, divisor_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic neg_ff, neg_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [LEVEL_W/2+COUNT_W-1:0] plo_ff, plo_in;
   logic [63:0] prod_ff, prod_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [COUNT_W-1:0] ramp_eff;
   logic [DIST_W-1:0] delta;
   logic [DIST_W-1:0] dist_mag;
   logic [DIST_W-1:0] quo_mag;
   logic [LEVEL_W-1:0] step_fix;
   logic [COUNT_W-1:0] n_sel;
   logic signed [LEVEL_W/2+COUNT_W:0] phi;
   logic [64:0] sum;
   logic [LEVEL_W-1:0] sum_sat;
   logic [COUNT_W-1:0] left_new;
   logic [DIST_W-1:0] rnd;
   logic [VALUE_W:0] rnd_q;
   logic [VALUE_W-1:0] out_sat;
   logic [COUNT_W-1:0] rem_v;
   logic [QUO_W-1:0] quo_v;
   logic [COUNT_W:0] shifted;

   assign ramp_eff = (ramp_length_ff == '0) ? COUNT_W'(1) : ramp_length_ff;
   assign delta = {req_ff.value[VALUE_W-1], req_ff.value, 16'h0000}
      - {current_ff[LEVEL_W-1], current_ff};
   assign dist_mag = delta[DIST_W-1] ? (DIST_W'(0) - delta) : delta;

   // two restoring steps per cycle
   always_comb begin
      rem_v = rem_ff;
      quo_v = quo_ff;
      shifted = '0;
      for (int i = 0; i < 2; i++) begin
         shifted = {rem_v, quo_v[QUO_W-1]};
         quo_v = {quo_v[QUO_W-2:0], 1'b0};
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_v = COUNT_W'(shifted - {1'b0, divisor_ff});
            quo_v[0] = 1'b1;
         end else begin
            rem_v = shifted[COUNT_W-1:0];
         end
      end
   end

   assign quo_mag = quo_ff[DIST_W-1:0];
   always_comb begin
      if (!neg_ff) begin
         if (quo_mag[DIST_W-1] | quo_mag[LEVEL_W-1]) begin
            step_fix = {1'b0, {(LEVEL_W-1){1'b1}}};
         end else begin
            step_fix = quo_mag[LEVEL_W-1:0];
         end
      end else begin
         if (quo_mag[DIST_W-1] | (quo_mag[LEVEL_W-1] & (|quo_mag[LEVEL_W-2:0]))) begin
            step_fix = {1'b1, {(LEVEL_W-1){1'b0}}};
         end else begin
            step_fix = LEVEL_W'(0) - quo_mag[LEVEL_W-1:0];
         end
      end
   end

   assign n_sel = (req_ff.sample_count < left_ff) ? req_ff.sample_count : left_ff;
   assign phi = $signed({{(COUNT_W+1){step_ff[LEVEL_W-1]}}, step_ff[LEVEL_W-1:LEVEL_W/2]})
      * $signed({{(LEVEL_W/2+1){1'b0}}, n_ff});

   assign sum = {{17{current_ff[LEVEL_W-1]}}, current_ff} + {prod_ff[63], prod_ff};
   always_comb begin
      if ((&sum[64:LEVEL_W-1]) || !(|sum[64:LEVEL_W-1])) begin
         sum_sat = sum[LEVEL_W-1:0];
      end else if (sum[64]) begin
         sum_sat = {1'b1, {(LEVEL_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(LEVEL_W-1){1'b1}}};
      end
   end
   assign left_new = left_ff - n_ff;

   // round the q32.16 level half up to a signed 32-bit value and saturate
   assign rnd = {current_ff[LEVEL_W-1], current_ff} + DIST_W'(32768);
   assign rnd_q = rnd[DIST_W-1:16];
   always_comb begin
      if (rnd_q[VALUE_W] != rnd_q[VALUE_W-1]) begin
         out_sat = rnd_q[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         out_sat = rnd_q[VALUE_W-1:0];
      end
   end

   always_comb begin
      req_in = req_ff;
      ramp_length_in = ramp_length_ff;
      current_in = current_ff;
      target_in = target_ff;
      step_in = step_ff;
      left_in = left_ff;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      n_in = n_ff;
      plo_in = plo_ff;
      prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;

      if (cmd.latch_req) begin
         req_in = req_payload;
      end
      if (cmd.div_load) begin
         target_in = req_ff.value;
         left_in = ramp_eff;
         divisor_in = ramp_eff;
         rem_in = '0;
         quo_in = {1'b0, dist_mag};
         neg_in = delta[DIST_W-1];
      end
      if (cmd.div_step) begin
         rem_in = rem_v;
         quo_in = quo_v;
      end
      if (cmd.div_finish) begin
         step_in = step_fix;
      end
      if (cmd.jump) begin
         target_in = req_ff.value;
         current_in = {req_ff.value, 16'h0000};
         step_in = '0;
         left_in = '0;
      end
      if (cmd.snap) begin
         current_in = {target_ff, 16'h0000};
      end
      if (cmd.mul_lo) begin
         n_in = n_sel;
         plo_in = {{COUNT_W{1'b0}}, step_ff[LEVEL_W/2-1:0]}
            * {{(LEVEL_W/2){1'b0}}, n_sel};
      end
      if (cmd.mul_hi) begin
         prod_in = {phi[LEVEL_W/2+COUNT_W-1:0], 24'h000000} + {24'h000000, plo_ff};
      end
      if (cmd.accum) begin
         left_in = left_new;
         current_in = (left_new == '0) ? {target_ff, 16'h0000} : sum_sat;
      end
      if (csr_write_enable) begin
         ramp_length_in = csr_write_data;
         left_in = '0;
         step_in = '0;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.current_value = out_sat;
         rsp_in.ramping = (left_ff != '0);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_length_ff <= COUNT_W'(1);
         current_ff <= '0;
         target_ff <= '0;
         step_ff <= '0;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ramp_length_ff <= ramp_length_in;
         current_ff <= current_in;
         target_ff <= target_in;
         step_ff <= step_in;
         left_ff <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      n_ff <= n_in;
      plo_ff <= plo_in;
      prod_ff <= prod_in;
      rsp_ff <= rsp_in;
   end

   assign status.op = req_ff.op;
   assign status.target_differs = (req_ff.value != target_ff);
   assign status.count_zero = (req_ff.sample_count == '0);
   assign status.left_zero = (left_ff == '0);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### design/lvs_ctrl.sv
`default_nettype none

module lvs_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire lvs_pkg::status_type status,
   output lvs_pkg::cmd_type cmd
);
   import lvs_pkg::*;

   state_type state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_count_ff, div_count_in;
   logic div_last;

   assign div_last = (div_count_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_SET_TARGET: state_in = status.target_differs ? ST_DIV : ST_RESULT;
               OP_ADVANCE: begin
                  if (!status.count_zero && !status.left_zero) begin
                     state_in = ST_MUL_HI;
                  end else begin
                     state_in = ST_RESULT;
                  end
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_DIV_FIX;
            end
         end
         ST_DIV_FIX: state_in = ST_RESULT;
         ST_MUL_HI: state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_RESULT;
         ST_RESULT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      div_count_in = div_count_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch_req = req_valid;
         end
         ST_DECODE: begin
            div_count_in = '0;
            case (status.op)
               OP_SET_TARGET: cmd.div_load = status.target_differs;
               OP_JUMP: cmd.jump = 1'b1;
               OP_ADVANCE: begin
                  if (!status.count_zero) begin
                     cmd.snap = status.left_zero;
                     cmd.mul_lo = !status.left_zero;
                  end
               end
               default: cmd = '0;
            endcase
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_count_in = div_count_ff + DIV_CNT_W'(1);
         end
         ST_DIV_FIX: cmd.div_finish = 1'b1;
         ST_MUL_HI: cmd.mul_hi = 1'b1;
         ST_ACCUM: cmd.accum = 1'b1;
         ST_RESULT: cmd.rsp_load = status.rsp_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         div_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         div_count_ff <= div_count_in;
      end
   end

endmodule

`default_nettype wire

### design/linear_value_smoother.sv
// channel   direction  ports                      accepted when
// request   in         req_valid/req_stall        req_valid && !req_stall
// response  out        rsp_valid/rsp_stall        rsp_valid && !rsp_stall
// csr       in         csr_write_enable/_data     csr_write_enable
//
// one request at a time; a response register lets the next request in early
// set target with a new value runs through the radix-4 step divider
// an advance inside a ramp runs a two-part multiply, then an add; other advances go straight to the result
// reset is synchronous; ramp_length returns to 1, all levels to zero
// a stalled response holds the block in its result state until taken
`default_nettype none

`include "linear_value_smoother_assert.svh"

module linear_value_smoother (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire lvs_pkg::req_type req_payload,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output lvs_pkg::rsp_type rsp_payload,
   input wire logic csr_write_enable,
   input wire logic [lvs_pkg::COUNT_W-1:0] csr_write_data
);
   import lvs_pkg::*;

   cmd_type cmd;
   status_type status;

   lvs_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   lvs_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_payload(req_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall(rsp_stall)
   );

   `LVS_ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one datapath command")
   `LVS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")
   `LVS_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.rsp_load, !rsp_valid || !rsp_stall, "pending response overwritten")
   `LVS_ASSERT_NEXT(a_load_then_valid, clock, reset, cmd.rsp_load, rsp_valid && !req_stall, "response not presented")

endmodule

`default_nettype wire
